>>> hdl/pee_pkg.sv
// Shared types and constants for the prefix expression evaluator.
package pee_pkg;

    localparam int SYMBOL_W    = 8;
    localparam int OUT_VALUE_W = 32;
    localparam int STATUS_W    = 3;
    // Multiplier digit size: one digit of the multiplier is consumed per cycle
    localparam int MUL_DIGIT_W = 8;

    localparam logic [SYMBOL_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [SYMBOL_W-1:0] CH_NINE  = 8'h39;
    localparam logic [SYMBOL_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [SYMBOL_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [SYMBOL_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [SYMBOL_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [SYMBOL_W-1:0] CH_CARET = 8'h5E;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 3'd0,
        ST_UNDER = 3'd1,
        ST_OVER  = 3'd2,
        ST_DIVZ  = 3'd3,
        ST_EMPTY = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_POW,
        OP_DROP
    } op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_A,
        S_RD_B,
        S_DISPATCH,
        S_MUL,
        S_DIV,
        S_PCHK,
        S_WB,
        S_TOP_RD,
        S_EMIT
    } state_t;

endpackage

>>> hdl/prefix_expression_evaluator.sv
// Run time of '*', '/' and '^' is set by the shared shift/multiply-digit unit
// (one 8-bit multiplier digit or one quotient bit per cycle), after both operands are read from the stack RAM.
// A transaction marked last then fetches the top of the stack and loads the output register.
// One transaction at a time; reset (aresetn low, synchronous) empties the stack.
module prefix_expression_evaluator #(
    parameter int STACK_DEPTH = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [pee_pkg::SYMBOL_W-1:0]        s_symbol,
    input  logic                                s_last,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [pee_pkg::OUT_VALUE_W-1:0] m_value,
    output logic [pee_pkg::STATUS_W-1:0]        m_status
);

    import pee_pkg::*;

    localparam int AW    = $clog2(STACK_DEPTH);
    localparam int SP_W  = $clog2(STACK_DEPTH + 1);
    localparam int MDIG  = (VALUE_WIDTH + MUL_DIGIT_W - 1) / MUL_DIGIT_W;
    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);
    localparam int W     = VALUE_WIDTH;

    state_t                 state_reg, state_next;
    op_t                    op_reg, op_next;
    logic                   last_reg, last_next;
    logic [SP_W-1:0]        sp_reg, sp_next;
    status_t                sticky_reg, sticky_next;
    logic [W-1:0]           a_reg, a_next;
    logic [W-1:0]           b_reg, b_next;
    logic [W-1:0]           res_reg, res_next;
    logic [W-1:0]           acc_reg, acc_next;
    logic [W-1:0]           cand_reg, cand_next;
    logic [W-1:0]           plier_reg, plier_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   neg_reg, neg_next;
    logic                   sq_reg, sq_next;
    logic                   m_valid_reg, m_valid_next;
    logic [OUT_VALUE_W-1:0] m_value_reg, m_value_next;
    status_t                m_status_reg, m_status_next;

    // RAM port signals
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [W-1:0]  ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [W-1:0]  ram_rdata;

    logic          s_fire;
    logic          is_digit;
    op_t           sym_op;
    logic          sp_full;
    logic          sp_short;
    logic [AW-1:0] sp_addr;
    logic          emit_ok;

    // Shared unit datapath
    logic [W+MUL_DIGIT_W-1:0] mul_prod;
    logic [W-1:0]             mul_sum;
    logic [W-1:0]             div_trial;
    logic                     div_ge;
    logic [W-1:0]             div_rem;
    logic [W-1:0]             div_quot;
    logic [W-1:0]             a_mag;
    logic [W-1:0]             b_mag;
    logic [W-1:0]             pow_neg_res;
    logic [63:0]              top_wide;

    pee_ram #(
        .WIDTH(W),
        .DEPTH(STACK_DEPTH)
    ) u_stack (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // Handshake and decode
    assign s_ready  = (state_reg == S_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign is_digit = (s_symbol >= CH_ZERO) && (s_symbol <= CH_NINE);
    assign sp_full  = (sp_reg == SP_W'(STACK_DEPTH));
    assign sp_short = (sp_reg < SP_W'(2));
    assign sp_addr  = sp_reg[AW-1:0];
    assign emit_ok  = (state_reg == S_EMIT) && (!m_valid_reg || m_ready);

    always_comb begin
        unique case (s_symbol)
            CH_PLUS:  sym_op = OP_ADD;
            CH_MINUS: sym_op = OP_SUB;
            CH_STAR:  sym_op = OP_MUL;
            CH_SLASH: sym_op = OP_DIV;
            CH_CARET: sym_op = OP_POW;
            default:  sym_op = OP_DROP;
        endcase
    end

    // Multiply step: accumulate cand times the low multiplier digit
    assign mul_prod = {{MUL_DIGIT_W{1'b0}}, cand_reg}
                    * {{W{1'b0}}, plier_reg[MUL_DIGIT_W-1:0]};
    assign mul_sum  = acc_reg + mul_prod[W-1:0];

    // Restoring divide step: remainder in acc, dividend/quotient in plier
    assign div_trial = {acc_reg[W-2:0], plier_reg[W-1]};
    assign div_ge    = (div_trial >= cand_reg);
    assign div_rem   = div_ge ? (div_trial - cand_reg) : div_trial;
    assign div_quot  = {plier_reg[W-2:0], div_ge};

    // Operand magnitudes; b comes straight off the RAM in dispatch
    assign a_mag = a_reg[W-1] ? (~a_reg + W'(1)) : a_reg;
    assign b_mag = ram_rdata[W-1] ? (~ram_rdata + W'(1)) : ram_rdata;

    // Power with negative exponent
    always_comb begin
        if (a_reg == W'(1)) begin
            pow_neg_res = W'(1);
        end else if (a_reg == {W{1'b1}}) begin
            pow_neg_res = ram_rdata[0] ? {W{1'b1}} : W'(1);
        end else begin
            pow_neg_res = '0;
        end
    end

    assign top_wide = 64'($signed(ram_rdata));

    // Next-state logic
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    if (is_digit || sp_short) begin
                        state_next = s_last ? S_TOP_RD : S_IDLE;
                    end else begin
                        state_next = S_RD_A;
                    end
                end
            end
            S_RD_A:     state_next = S_RD_B;
            S_RD_B:     state_next = S_DISPATCH;
            S_DISPATCH: begin
                unique case (op_reg)
                    OP_ADD, OP_SUB: state_next = S_WB;
                    OP_MUL:         state_next = S_MUL;
                    OP_DIV:         state_next = (ram_rdata == '0) ? S_WB : S_DIV;
                    OP_POW:         state_next = ram_rdata[W-1] ? S_WB : S_PCHK;
                    default:        state_next = last_reg ? S_TOP_RD : S_IDLE;
                endcase
            end
            S_MUL: begin
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = (op_reg == OP_MUL) ? S_WB : S_PCHK;
                end
            end
            S_DIV: begin
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = S_WB;
                end
            end
            S_PCHK:   state_next = (b_reg == '0) ? S_WB : S_MUL;
            S_WB:     state_next = last_reg ? S_TOP_RD : S_IDLE;
            S_TOP_RD: state_next = S_EMIT;
            S_EMIT: begin
                if (emit_ok) begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // Datapath and output logic
    always_comb begin
        op_next       = op_reg;
        last_next     = last_reg;
        sp_next       = sp_reg;
        sticky_next   = sticky_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        res_next      = res_reg;
        acc_next      = acc_reg;
        cand_next     = cand_reg;
        plier_next    = plier_reg;
        cnt_next      = cnt_reg;
        neg_next      = neg_reg;
        sq_next       = sq_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_value_next  = m_value_reg;
        m_status_next = m_status_reg;
        ram_we        = 1'b0;
        ram_waddr     = sp_addr;
        ram_wdata     = res_reg;
        ram_re        = 1'b0;
        ram_raddr     = sp_addr - AW'(1);

        unique case (state_reg)
            // Take a character: push digits (overflow flagged when full), screen operators for underflow
            S_IDLE: begin
                if (s_fire) begin
                    op_next   = sym_op;
                    last_next = s_last;
                    if (is_digit) begin
                        if (sp_full) begin
                            sticky_next = (sticky_reg == ST_OK) ? ST_OVER : sticky_reg;
                        end else begin
                            ram_we    = 1'b1;
                            ram_wdata = W'(s_symbol - CH_ZERO);
                            sp_next   = sp_reg + SP_W'(1);
                        end
                    end else if (sp_short) begin
                        sticky_next = (sticky_reg == ST_OK) ? ST_UNDER : sticky_reg;
                    end
                end
            end
            S_RD_A: begin
                ram_re = 1'b1;
            end
            S_RD_B: begin
                ram_re    = 1'b1;
                ram_raddr = sp_addr - AW'(2);
                a_next    = ram_rdata;
            end
            // a in a_reg, b on the RAM output
            S_DISPATCH: begin
                sp_next = sp_reg - SP_W'(2);
                b_next  = ram_rdata;
                unique case (op_reg)
                    OP_ADD: res_next = a_reg + ram_rdata;
                    OP_SUB: res_next = a_reg - ram_rdata;
                    OP_MUL: begin
                        acc_next   = '0;
                        cand_next  = a_reg;
                        plier_next = ram_rdata;
                        cnt_next   = CNT_W'(MDIG);
                    end
                    OP_DIV: begin
                        if (ram_rdata == '0) begin
                            sticky_next = (sticky_reg == ST_OK) ? ST_DIVZ : sticky_reg;
                            res_next    = '0;
                        end else begin
                            acc_next   = '0;
                            plier_next = a_mag;
                            cand_next  = b_mag;
                            cnt_next   = CNT_W'(W);
                            neg_next   = a_reg[W-1] ^ ram_rdata[W-1];
                        end
                    end
                    OP_POW: begin
                        res_next = ram_rdata[W-1] ? pow_neg_res : W'(1);
                    end
                    default: ;
                endcase
            end
            S_MUL: begin
                acc_next   = mul_sum;
                cand_next  = cand_reg << MUL_DIGIT_W;
                plier_next = plier_reg >> MUL_DIGIT_W;
                cnt_next   = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    if (op_reg == OP_MUL) begin
                        res_next = mul_sum;
                    end else if (sq_reg) begin
                        a_next = mul_sum;
                    end else begin
                        res_next = mul_sum;
                        b_next   = {b_reg[W-1:1], 1'b0};
                    end
                end
            end
            S_DIV: begin
                acc_next   = div_rem;
                plier_next = div_quot;
                cnt_next   = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    res_next = neg_reg ? (~div_quot + W'(1)) : div_quot;
                end
            end
            // Square-and-multiply: res is the running result, a the base, b the exponent
            S_PCHK: begin
                if (b_reg != '0) begin
                    acc_next = '0;
                    cnt_next = CNT_W'(MDIG);
                    if (b_reg[0]) begin
                        cand_next  = res_reg;
                        plier_next = a_reg;
                        sq_next    = 1'b0;
                    end else begin
                        cand_next  = a_reg;
                        plier_next = a_reg;
                        sq_next    = 1'b1;
                        b_next     = b_reg >> 1;
                    end
                end
            end
            S_WB: begin
                ram_we  = 1'b1;
                sp_next = sp_reg + SP_W'(1);
            end
            S_TOP_RD: begin
                ram_re = 1'b1;
            end
            // Load the output register and return to the empty state
            S_EMIT: begin
                if (emit_ok) begin
                    m_valid_next = 1'b1;
                    if (sp_reg == '0) begin
                        m_value_next  = '0;
                        m_status_next = (sticky_reg == ST_OK) ? ST_EMPTY : sticky_reg;
                    end else begin
                        m_value_next  = top_wide[OUT_VALUE_W-1:0];
                        m_status_next = sticky_reg;
                    end
                    sp_next     = '0;
                    sticky_next = ST_OK;
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            sp_reg      <= '0;
            sticky_reg  <= ST_OK;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sp_reg      <= sp_next;
            sticky_reg  <= sticky_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        last_reg     <= last_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        res_reg      <= res_next;
        acc_reg      <= acc_next;
        cand_reg     <= cand_next;
        plier_reg    <= plier_next;
        cnt_reg      <= cnt_next;
        neg_reg      <= neg_next;
        sq_reg       <= sq_next;
        m_value_reg  <= m_value_next;
        m_status_reg <= m_status_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_value  = m_value_reg;
    assign m_status = m_status_reg;

    // Stack pointer never passes the stack depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        sp_reg <= SP_W'(STACK_DEPTH))
        else $error("stack pointer beyond depth");

    // A result transaction leaves an empty stack and clear status
    assert property (@(posedge aclk) disable iff (!aresetn)
        emit_ok |=> (sp_reg == '0) && (sticky_reg == ST_OK))
        else $error("state not cleared after result");

    // The first error is held until the result is loaded
    assert property (@(posedge aclk) disable iff (!aresetn)
        (sticky_reg != ST_OK) && !emit_ok |=> $stable(sticky_reg))
        else $error("sticky status changed");

    // A new result only comes from the emit state
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == S_EMIT)
        else $error("result raised outside emit");

    // The shared unit never runs with an exhausted step count
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MUL) || (state_reg == S_DIV) |-> cnt_reg != '0)
        else $error("shared unit step count zero");

endmodule

>>> hdl/pee_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pee_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
